@@ rtl/luma_histogram_with_peak_top_assert.svh @@
// Assertion macros for the luma histogram block.
// Uses the clk and rst_n names of the module that includes it.
`ifndef LUMA_HISTOGRAM_WITH_PEAK_TOP_ASSERT_SVH
`define LUMA_HISTOGRAM_WITH_PEAK_TOP_ASSERT_SVH

// Same-cycle implication.
`define LHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Delayed implication.
`define LHP_ASSERT_DLY2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

@@ rtl/lhp_pkg.sv @@
// Shared types and constants for the luma histogram block.
// No dependencies.
package lhp_pkg;

  localparam int BINS     = 256;
  localparam int BIN_W    = 8;
  localparam int OUT_W    = 24;
  localparam int LUMA_W   = 24;
  localparam int QDEPTH   = 4;   // power of two, pointers wrap naturally
  localparam int PTR_W    = $clog2(QDEPTH);
  localparam int LVL_W    = $clog2(QDEPTH + 1);

  // Q16 luma weights, sum is exactly 65536
  localparam logic [15:0] W_RED   = 16'd19595;
  localparam logic [15:0] W_GREEN = 16'd38470;
  localparam logic [15:0] W_BLUE  = 16'd7471;

  // input mode codes
  localparam logic [1:0] MODE_ACCUM = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    KIND_ACCUM,
    KIND_READ,
    KIND_CLEAR,
    KIND_NOP
  } lhp_kind_t;

  typedef enum logic {
    BK_IDLE,
    BK_UPDATE
  } lhp_bk_state_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
    logic [7:0]       gray_level;
    logic [7:0]       read_bin;
  } lhp_in_t;

  typedef struct packed {
    logic [BIN_W-1:0] bin_index;
    logic [OUT_W-1:0] bin_count;
    logic [OUT_W-1:0] peak_count;
  } lhp_out_t;

  // classified operation passed from front to back
  typedef struct packed {
    lhp_kind_t        kind;
    logic [BIN_W-1:0] bin;
  } lhp_op_t;

  // queue status seen by the back end and the top level
  typedef struct packed {
    logic             empty;
    logic [LVL_W-1:0] level;
  } lhp_qstat_t;

endpackage

@@ rtl/luma_histogram_with_peak_top.sv @@
// Accepted items pass the front stage, op queue and back end to the result
// strobe (out_valid). The back end pops a new op only once the bin memory
// read-modify-write of the last is done (read, then update and write). busy
// rises once queued ops plus the front-stage op reach 4, the op queue depth.
// No rx stall. Reset is synchronous, active low; bin valid flops clear at
// once, no clearing pass, so items are taken from the first cycle after reset.
`include "luma_histogram_with_peak_top_assert.svh"

module luma_histogram_with_peak_top
  import lhp_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  lhp_in_t  in_item,
  output logic     out_valid,
  output lhp_out_t out_item,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_data
);

  logic       pixel_format_r;
  logic       accept;
  logic       q_push, q_pop;
  lhp_op_t    push_op, q_head;
  lhp_qstat_t q_stat;
  logic       front_busy_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_format_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      pixel_format_r <= cfg_data;
    end
  end

  // reserve a queue slot for the item in the front stage
  assign busy   = ({1'b0, q_stat.level} + (LVL_W + 1)'(front_busy_r))
                  >= (LVL_W + 1)'(QDEPTH);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_busy_r <= 1'b0;
    end else begin
      front_busy_r <= accept;
    end
  end

  lhp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .in_item      (in_item),
    .pixel_format (pixel_format_r),
    .push         (q_push),
    .push_op      (push_op)
  );

  lhp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (push_op),
    .pop     (q_pop),
    .head    (q_head),
    .stat    (q_stat)
  );

  lhp_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .qstat     (q_stat),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  `LHP_ASSERT_NOW(a_q_bound, 1'b1, q_stat.level <= LVL_W'(QDEPTH), "op queue overflow")
  `LHP_ASSERT_NOW(a_push_room, q_push, q_stat.level < LVL_W'(QDEPTH), "push into full queue")
  `LHP_ASSERT_DLY2(a_pop_result, q_pop, out_valid, "popped op gave no result")

endmodule

@@ rtl/lhp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lhp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/lhp_front.sv @@
// Front end: takes items, forms the luma products, picks the bin and kind.
// Depends on lhp_pkg.
module lhp_front
  import lhp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    accept,
  input  lhp_in_t in_item,
  input  logic    pixel_format,
  output logic    push,
  output lhp_op_t push_op
);

  logic              s1_valid_r;
  lhp_kind_t         kind_r, kind_nxt;
  logic [LUMA_W-1:0] prod_r_r, prod_g_r, prod_b_r;
  logic [7:0]        gray_r, rbin_r;
  logic              fmt_r;
  logic [LUMA_W-1:0] luma_sum;
  logic [BIN_W-1:0]  bin_sel;

  always_comb begin
    case (in_item.mode)
      MODE_ACCUM: kind_nxt = KIND_ACCUM;
      MODE_READ:  kind_nxt = KIND_READ;
      MODE_CLEAR: kind_nxt = KIND_CLEAR;
      default:    kind_nxt = KIND_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= kind_nxt;
      prod_r_r <= LUMA_W'(W_RED) * LUMA_W'(in_item.red);
      prod_g_r <= LUMA_W'(W_GREEN) * LUMA_W'(in_item.green);
      prod_b_r <= LUMA_W'(W_BLUE) * LUMA_W'(in_item.blue);
      gray_r   <= in_item.gray_level;
      rbin_r   <= in_item.read_bin;
      fmt_r    <= pixel_format;
    end
  end

  // weights sum to 2^16, so the sum never exceeds 24 bits
  assign luma_sum = prod_r_r + prod_g_r + prod_b_r;

  always_comb begin
    case (kind_r)
      KIND_ACCUM: bin_sel = fmt_r ? gray_r : luma_sum[LUMA_W-1:16];
      KIND_READ:  bin_sel = rbin_r;
      default:    bin_sel = '0;
    endcase
  end

  assign push         = s1_valid_r;
  assign push_op.kind = kind_r;
  assign push_op.bin  = bin_sel;

endmodule

@@ rtl/lhp_queue.sv @@
// Small FIFO of classified ops between front and back end.
// Depends on lhp_pkg.
module lhp_queue
  import lhp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  lhp_op_t    push_op,
  input  logic       pop,
  output lhp_op_t    head,
  output lhp_qstat_t stat
);

  lhp_op_t          ent_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [LVL_W-1:0] level_r, level_nxt;

  always_comb begin
    level_nxt = level_r;
    case ({push, pop})
      2'b10:   level_nxt = level_r + LVL_W'(1);
      2'b01:   level_nxt = level_r - LVL_W'(1);
      default: level_nxt = level_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
      level_r <= level_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_op;
    end
  end

  assign head       = ent_r[rd_ptr_r];
  assign stat.empty = (level_r == '0);
  assign stat.level = level_r;

endmodule

@@ rtl/lhp_back.sv @@
// Back end: read-modify-write of the bin memory, peak tracking, result register.
// Depends on lhp_pkg and lhp_ram.
module lhp_back
  import lhp_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  logic       clk,
  input  logic       rst_n,
  input  lhp_op_t    head,
  input  lhp_qstat_t qstat,
  output logic       pop,
  output logic       out_valid,
  output lhp_out_t   out_item
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  lhp_bk_state_t         state_r, state_nxt;
  lhp_op_t               op_r, op_nxt;
  logic [BINS-1:0]       valid_r, valid_nxt;
  logic [COUNT_BITS-1:0] peak_r, peak_nxt;
  logic                  out_valid_r, out_valid_nxt;
  lhp_out_t              out_item_r, out_item_nxt;

  logic                  ram_we, ram_re;
  logic [COUNT_BITS-1:0] ram_rdata, cur_cnt, inc_cnt;

  lhp_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (op_r.bin),
    .wdata (inc_cnt),
    .re    (ram_re),
    .raddr (head.bin),
    .rdata (ram_rdata)
  );

  // an untouched bin reads as zero
  assign cur_cnt = valid_r[op_r.bin] ? ram_rdata : '0;
  assign inc_cnt = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + COUNT_BITS'(1);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    valid_nxt     = valid_r;
    peak_nxt      = peak_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    pop           = 1'b0;
    ram_re        = 1'b0;
    ram_we        = 1'b0;
    case (state_r)
      BK_IDLE: begin
        if (!qstat.empty) begin
          pop       = 1'b1;
          ram_re    = 1'b1;
          op_nxt    = head;
          state_nxt = BK_UPDATE;
        end
      end
      BK_UPDATE: begin
        out_valid_nxt          = 1'b1;
        out_item_nxt.bin_index = op_r.bin;
        case (op_r.kind)
          KIND_ACCUM: begin
            ram_we              = 1'b1;
            valid_nxt[op_r.bin] = 1'b1;
            if (inc_cnt > peak_r) begin
              peak_nxt = inc_cnt;
            end
            out_item_nxt.bin_count = OUT_W'(inc_cnt);
          end
          KIND_READ: begin
            out_item_nxt.bin_count = OUT_W'(cur_cnt);
          end
          KIND_CLEAR: begin
            valid_nxt              = '0;
            peak_nxt               = '0;
            out_item_nxt.bin_count = '0;
          end
          default: begin
            out_item_nxt.bin_count = '0;
          end
        endcase
        out_item_nxt.peak_count = OUT_W'(peak_nxt);
        state_nxt               = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      valid_r     <= '0;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
